FILE: rtl/bank_switch_mapper_scanline_irq_defines.svh
// Assertion macros for the bank-switching mapper.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef BANK_SWITCH_MAPPER_SCANLINE_IRQ_DEFINES_SVH
`define BANK_SWITCH_MAPPER_SCANLINE_IRQ_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BSM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bsm_pkg.sv
// Shared types and codes for the bank-switching mapper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bsm_pkg;

	// access codes
	localparam logic [2:0] FUNC_CPU_RD   = 3'd0;
	localparam logic [2:0] FUNC_CPU_WR   = 3'd1;
	localparam logic [2:0] FUNC_PPU_RD   = 3'd2;
	localparam logic [2:0] FUNC_PPU_WR   = 3'd3;
	localparam logic [2:0] FUNC_SCANLINE = 3'd4;

	// CPU write windows, addr[14:13] above $8000
	localparam logic [1:0] WIN_BANK   = 2'd0;
	localparam logic [1:0] WIN_MIRROR = 2'd1;
	localparam logic [1:0] WIN_IRQ_LD = 2'd2;
	localparam logic [1:0] WIN_IRQ_EN = 2'd3;

	// mirroring codes
	localparam logic [1:0] MIRROR_HW   = 2'd0;
	localparam logic [1:0] MIRROR_VERT = 2'd1;
	localparam logic [1:0] MIRROR_HORZ = 2'd2;

	// configuration register indexes (paddr[2])
	localparam logic REG_PRG_BANK_COUNT = 1'b0;
	localparam logic REG_CHR_BANK_COUNT = 1'b1;

	localparam int PADDR_W = 3;

	localparam logic [5:0] PRG_COUNT_RESET = 6'd32;
	localparam logic [7:0] CHR_COUNT_RESET = 8'd0;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] addr;
		logic [7:0]  data;
	} in_word_t;

	typedef struct packed {
		logic        handled;
		logic [18:0] mapped_addr;
		logic [1:0]  mirror_mode;
		logic        irq_pending;
	} out_word_t;

	typedef struct packed {
		logic [5:0] prg_bank_count;
		logic [7:0] chr_bank_count;
	} cfg_t;

endpackage

FILE: rtl/bsm_cfg_regs.sv
// APB configuration registers of the mapper: program and character bank counts.
// Depends on bsm_pkg.
`timescale 1ns / 1ps

module bsm_cfg_regs
	import bsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [5:0] prg_count_q;
	logic [7:0] chr_count_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= PRG_COUNT_RESET;
			chr_count_q <= CHR_COUNT_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_PRG_BANK_COUNT) begin
				prg_count_q <= pwdata[5:0];
			end else begin
				chr_count_q <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_CHR_BANK_COUNT) begin
			prdata = {24'd0, chr_count_q};
		end else begin
			prdata = {26'd0, prg_count_q};
		end
	end

	assign cfg.prg_bank_count = prg_count_q;
	assign cfg.chr_bank_count = chr_count_q;

endmodule

FILE: rtl/bsm_core.sv
// Mapper state (bank registers, mirroring, scanline IRQ) and address mapping.
// Forms one result word per item from the current state; depends on bsm_pkg.
`timescale 1ns / 1ps

module bsm_core
	import bsm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  in_word_t  item,
	input  logic      fire,
	output out_word_t result
);

	logic [7:0] bank_select_q;
	logic [7:0] bank_regs_q [8];
	logic [1:0] mirror_q;
	logic [7:0] irq_latch_q;
	logic [7:0] irq_counter_q;
	logic       irq_reload_q;
	logic       irq_enable_q;
	logic       irq_active_q;

	logic [1:0] mirror_d;
	logic [7:0] irq_counter_d;
	logic       irq_reload_d;
	logic       irq_enable_d;
	logic       irq_active_d;
	logic [7:0] scan_count;

	logic       odd;
	logic       wr_sel;
	logic       wr_bank;
	logic [5:0] last_bank;
	logic [5:0] fixed1;
	logic [5:0] fixed2;
	logic [5:0] prg_bank;
	logic       swap_prg;
	logic [12:0] chr_a;
	logic [7:0] chr_bank;
	logic [2:0] chr_idx;
	logic [18:0] prg_off;
	logic [18:0] chr_off;
	logic       ppu_in_range;

	assign odd    = item.addr[0];
	assign wr_sel = (item.func == FUNC_CPU_WR) && item.addr[15];
	// even $8000 picks the register, odd $8001 writes it
	assign wr_bank = wr_sel && (item.addr[14:13] == WIN_BANK);

	// program mapping: fixed banks wrap in six bank lines
	assign last_bank = {cfg.prg_bank_count[4:0], 1'b0};
	assign fixed1    = last_bank - 6'd1;
	assign fixed2    = last_bank - 6'd2;
	assign swap_prg  = bank_select_q[6];

	always_comb begin
		case (item.addr[14:13])
			2'd0:    prg_bank = swap_prg ? fixed2 : bank_regs_q[6][5:0];
			2'd1:    prg_bank = bank_regs_q[7][5:0];
			2'd2:    prg_bank = swap_prg ? bank_regs_q[6][5:0] : fixed2;
			default: prg_bank = fixed1;
		endcase
	end
	assign prg_off = {prg_bank, item.addr[12:0]};

	// character mapping: swap pattern table halves when inverted
	assign chr_a   = {item.addr[12] ^ bank_select_q[7], item.addr[11:0]};
	assign chr_idx = {1'b0, chr_a[11:10]} + 3'd2;
	always_comb begin
		if (!chr_a[12]) begin
			if (!chr_a[11]) begin
				chr_bank = {bank_regs_q[0][7:1], chr_a[10]};
			end else begin
				chr_bank = {bank_regs_q[1][7:1], chr_a[10]};
			end
		end else begin
			chr_bank = bank_regs_q[chr_idx];
		end
	end
	assign chr_off      = {1'b0, chr_bank, chr_a[9:0]};
	assign ppu_in_range = (item.addr[15:13] == 3'd0);

	// next state of mirroring and IRQ
	assign scan_count = ((irq_counter_q == 8'd0) || irq_reload_q) ? irq_latch_q
		: irq_counter_q - 8'd1;

	always_comb begin
		mirror_d      = mirror_q;
		irq_counter_d = irq_counter_q;
		irq_reload_d  = irq_reload_q;
		irq_enable_d  = irq_enable_q;
		irq_active_d  = irq_active_q;
		if (wr_sel) begin
			case (item.addr[14:13])
				WIN_MIRROR: begin
					if (!odd) begin
						mirror_d = item.data[0] ? MIRROR_HORZ : MIRROR_VERT;
					end
				end
				WIN_IRQ_LD: begin
					if (odd) begin
						irq_counter_d = 8'd0;
						irq_reload_d  = 1'b1;
					end
				end
				WIN_IRQ_EN: begin
					if (odd) begin
						irq_enable_d = 1'b1;
					end else begin
						irq_enable_d = 1'b0;
						irq_active_d = 1'b0;
					end
				end
				default: ;
			endcase
		end else if (item.func == FUNC_SCANLINE) begin
			irq_counter_d = scan_count;
			irq_reload_d  = 1'b0;
			if ((scan_count == 8'd0) && irq_enable_q) begin
				irq_active_d = 1'b1;
			end
		end
	end

	always_comb begin
		result.handled     = 1'b0;
		result.mapped_addr = '0;
		case (item.func)
			FUNC_CPU_RD: begin
				if (item.addr[15]) begin
					result.handled     = 1'b1;
					result.mapped_addr = prg_off;
				end
			end
			FUNC_PPU_RD: begin
				if (ppu_in_range) begin
					result.handled     = 1'b1;
					result.mapped_addr = chr_off;
				end
			end
			FUNC_PPU_WR: begin
				if (ppu_in_range && (cfg.chr_bank_count == 8'd0)) begin
					result.handled     = 1'b1;
					result.mapped_addr = chr_off;
				end
			end
			default: ;
		endcase
		result.mirror_mode = mirror_d;
		result.irq_pending = irq_active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q <= '0;
			for (int i = 0; i < 8; i++) begin
				bank_regs_q[i] <= '0;
			end
			mirror_q      <= MIRROR_HW;
			irq_latch_q   <= '0;
			irq_counter_q <= '0;
			irq_reload_q  <= 1'b0;
			irq_enable_q  <= 1'b0;
			irq_active_q  <= 1'b0;
		end else if (fire) begin
			if (wr_bank && !odd) begin
				bank_select_q <= item.data;
			end
			if (wr_bank && odd) begin
				bank_regs_q[bank_select_q[2:0]] <= item.data;
			end
			if (wr_sel && (item.addr[14:13] == WIN_IRQ_LD) && !odd) begin
				irq_latch_q <= item.data;
			end
			mirror_q      <= mirror_d;
			irq_counter_q <= irq_counter_d;
			irq_reload_q  <= irq_reload_d;
			irq_enable_q  <= irq_enable_d;
			irq_active_q  <= irq_active_d;
		end
	end

endmodule

FILE: rtl/bank_switch_mapper_scanline_irq.sv
// Bank-switching cartridge mapper with scanline IRQ counter.
// Usage:
//   Input channel in_valid/in_stall/in_word carries one access word: CPU read,
//   CPU write, PPU read, PPU write or scanline tick, with address and data.
//   Output channel out_valid/out_stall/out_word returns one result word per
//   access: handled flag, mapped byte offset, mirroring and IRQ request as
//   they stand after that access.
//   Throughput is one word per cycle unless the receiver stalls. The accepted
//   word lands in the input register, and its result moves on into the output
//   register, where out_valid rises, once it is free. All mapping and state
//   update is a single pass of mux logic between those two registers.
//   When the receiver stalls, the output word holds; the input register still
//   fills behind it, and in_stall rises only when both are full.
//   Reset clears all bank, mirroring and IRQ state, empties both registers
//   and sets prg_bank_count to 32, chr_bank_count to 0.
//   APB registers: 0x0 prg_bank_count, 0x4 chr_bank_count; write them idle.
// Depends on bsm_pkg, bsm_cfg_regs, bsm_core and the defines header.
`timescale 1ns / 1ps
`include "bank_switch_mapper_scanline_irq_defines.svh"

module bank_switch_mapper_scanline_irq
	import bsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_word_t           in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output out_word_t          out_word
);

	cfg_t      cfg;
	in_word_t  item_s1;
	logic      valid_s1;
	out_word_t result;
	out_word_t out_q;
	logic      out_valid_q;
	logic      out_free;
	logic      fire;
	logic      in_take;

	bsm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bsm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (fire),
		.result (result)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// hold the result word while stalled
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	`BSM_ASSERT_IMPL(a_unhandled_zero, out_valid_q && !out_q.handled, out_q.mapped_addr == 19'd0, "unhandled result carries a nonzero address")
	`BSM_ASSERT_NEXT(a_s1_held, valid_s1 && !out_free, valid_s1, "stalled input word lost")
	`BSM_ASSERT_NEXT(a_fire_fills_out, fire, out_valid_q, "processed word did not reach output")

endmodule
